@@ sv/irn_pkg.sv @@
`default_nettype none
package irn_pkg;

	// Source image geometry.
	localparam int SRC_W = 256;
	localparam int SRC_H = 256;
	localparam int AW    = $clog2(SRC_W * SRC_H);

	// Data path widths.
	localparam int RGBA_W    = 32;
	localparam int COORD_W   = 8;
	localparam int FRAC_BITS = 14;
	localparam int PROD_W    = 25;
	localparam int SUM_W     = 28;
	localparam int RND_W     = SUM_W - FRAC_BITS + 1;

	// Queue between the front and back parts.
	localparam int CMD_DEPTH = 8;
	localparam int CMD_PW    = $clog2(CMD_DEPTH);
	localparam int CMD_CW    = $clog2(CMD_DEPTH + 1);

	// Result queue in the back part.
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PW    = $clog2(OQ_DEPTH);
	localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COS      = 3'd0,
		CFG_SIN      = 3'd1,
		CFG_DST_CX   = 3'd2,
		CFG_DST_CY   = 3'd3,
		CFG_SRC_OFFX = 3'd4,
		CFG_SRC_OFFY = 3'd5
	} cfg_idx_t;

	// Item function codes.
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_MAP   = 1'b1;

	// One command handed from the front part to the back part.
	typedef struct packed {
		logic              wr;
		logic              hit;
		logic [AW-1:0]     addr;
		logic [RGBA_W-1:0] data;
	} cmd_t;

endpackage
`default_nettype wire

@@ sv/image_rotate_nearest_sampler.sv @@
// Map items pass the front stages, command queue, registered RAM read and result queue.
// Throughput: one item per cycle while the result queue has room; the back part sets it.
// Write items produce no result and take the same path to keep memory order.
// Reset clears all control state and loads the register defaults at once.
// The source image memory is not cleared and holds undefined data until written.
`default_nettype none
module image_rotate_nearest_sampler import irn_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	output logic                       full,
	input  wire logic                  func,
	input  wire logic [COORD_W-1:0]    coord_x,
	input  wire logic [COORD_W-1:0]    coord_y,
	input  wire logic [RGBA_W-1:0]     rgba_in,
	output logic                       empty,
	input  wire logic                  pop,
	output logic [RGBA_W-1:0]          rgba_out,
	output logic                       hit,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic cmd_push, cmd_pop;
	cmd_t cmd_in, cmd_out;
	logic [CMD_CW-1:0] cmd_count;

	// Front part: accepts items, computes the source coordinate, classifies.
	irn_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.func     (func),
		.coord_x  (coord_x),
		.coord_y  (coord_y),
		.rgba_in  (rgba_in),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.q_count  (cmd_count),
		.cmd_push (cmd_push),
		.cmd_out  (cmd_in)
	);

	// Command queue between the two parts.
	irn_cmd_queue u_cmd_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cmd_push),
		.din   (cmd_in),
		.pop   (cmd_pop),
		.dout  (cmd_out),
		.count (cmd_count)
	);

	// Back part: memory access and result queue.
	irn_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_count(cmd_count),
		.cmd_in   (cmd_out),
		.cmd_pop  (cmd_pop),
		.empty    (empty),
		.pop      (pop),
		.rgba_out (rgba_out),
		.hit      (hit)
	);

endmodule
`default_nettype wire

@@ sv/irn_ram.sv @@
`default_nettype none
module irn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

@@ sv/irn_front.sv @@
`default_nettype none
module irn_front import irn_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	output logic                       full,
	input  wire logic                  func,
	input  wire logic [COORD_W-1:0]    coord_x,
	input  wire logic [COORD_W-1:0]    coord_y,
	input  wire logic [RGBA_W-1:0]     rgba_in,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic [CMD_CW-1:0]     q_count,
	output logic                       cmd_push,
	output cmd_t                       cmd_out
);

	localparam logic signed [RND_W-1:0] SRC_W_S = RND_W'(SRC_W);
	localparam logic signed [RND_W-1:0] SRC_H_S = RND_W'(SRC_H);
	localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_BITS - 1);

	logic signed [15:0] cos_q, sin_q;
	logic [7:0] dcx_q, dcy_q;
	logic signed [10:0] offx_q, offy_q;

	logic accept;
	logic [CMD_CW:0] occ;
	logic signed [8:0] tx, ty;

	logic v_s1, v_s2, v_s3;
	logic func_s1, func_s2, func_s3;
	logic [COORD_W-1:0] cx_s1, cx_s2, cx_s3, cy_s1, cy_s2, cy_s3;
	logic [RGBA_W-1:0] rgba_s1, rgba_s2, rgba_s3;
	logic signed [PROD_W-1:0] pxc_s1, pys_s1, pyc_s1, pxs_s1;
	logic signed [SUM_W-1:0] vx_s2, vy_s2;
	logic signed [RND_W-1:0] sx_s3, sy_s3;

	logic signed [SUM_W-1:0] ox, oy;
	logic [SUM_W-1:0] magx, magy;
	logic [SUM_W-1:0] rx_full, ry_full;
	logic [RND_W-1:0] rx, ry;
	logic sx_in, sy_in, wr_in;

	// Configuration registers; the port never stalls.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q  <= 16'sd16384;
			sin_q  <= 16'sd0;
			dcx_q  <= 8'd64;
			dcy_q  <= 8'd64;
			offx_q <= 11'sd64;
			offy_q <= 11'sd64;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_COS:      cos_q  <= cfg_data;
				CFG_SIN:      sin_q  <= cfg_data;
				CFG_DST_CX:   dcx_q  <= cfg_data[7:0];
				CFG_DST_CY:   dcy_q  <= cfg_data[7:0];
				CFG_SRC_OFFX: offx_q <= cfg_data[10:0];
				CFG_SRC_OFFY: offy_q <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	// Admission: items in flight plus queued commands never exceed the queue depth.
	assign occ = (CMD_CW+1)'(q_count) + (CMD_CW+1)'(v_s1) + (CMD_CW+1)'(v_s2)
		+ (CMD_CW+1)'(v_s3);
	assign full = occ >= (CMD_CW+1)'(CMD_DEPTH);
	assign accept = push && !full;

	// Translate by the destination center.
	assign tx = $signed({1'b0, coord_x}) - $signed({1'b0, dcx_q});
	assign ty = $signed({1'b0, coord_y}) - $signed({1'b0, dcy_q});

	// Valid bits of the three stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1: the four rotation products.
	always_ff @(posedge clk) begin
		func_s1 <= func;
		cx_s1   <= coord_x;
		cy_s1   <= coord_y;
		rgba_s1 <= rgba_in;
		pxc_s1  <= tx * cos_q;
		pys_s1  <= ty * sin_q;
		pyc_s1  <= ty * cos_q;
		pxs_s1  <= tx * sin_q;
	end

	// Stage 2: sums with the source offsets in Q14.
	assign ox = SUM_W'(offx_q) <<< FRAC_BITS;
	assign oy = SUM_W'(offy_q) <<< FRAC_BITS;

	always_ff @(posedge clk) begin
		func_s2 <= func_s1;
		cx_s2   <= cx_s1;
		cy_s2   <= cy_s1;
		rgba_s2 <= rgba_s1;
		vx_s2   <= SUM_W'(pxc_s1) + SUM_W'(pys_s1) + ox;
		vy_s2   <= SUM_W'(pyc_s1) - SUM_W'(pxs_s1) + oy;
	end

	// Stage 3: round half away from zero on the magnitude.
	always_comb begin
		magx    = vx_s2[SUM_W-1] ? SUM_W'(-vx_s2) : SUM_W'(vx_s2);
		magy    = vy_s2[SUM_W-1] ? SUM_W'(-vy_s2) : SUM_W'(vy_s2);
		rx_full = (magx + HALF) >> FRAC_BITS;
		ry_full = (magy + HALF) >> FRAC_BITS;
		rx      = rx_full[RND_W-1:0];
		ry      = ry_full[RND_W-1:0];
	end

	always_ff @(posedge clk) begin
		func_s3 <= func_s2;
		cx_s3   <= cx_s2;
		cy_s3   <= cy_s2;
		rgba_s3 <= rgba_s2;
		sx_s3   <= vx_s2[SUM_W-1] ? $signed(-rx) : $signed(rx);
		sy_s3   <= vy_s2[SUM_W-1] ? $signed(-ry) : $signed(ry);
	end

	// Classify into a memory write or a memory read and form the address.
	always_comb begin
		sx_in = !sx_s3[RND_W-1] && (sx_s3 < SRC_W_S);
		sy_in = !sy_s3[RND_W-1] && (sy_s3 < SRC_H_S);
		wr_in = (int'(cx_s3) < SRC_W) && (int'(cy_s3) < SRC_H);
		cmd_push     = v_s3;
		cmd_out.wr   = (func_s3 == FUNC_WRITE);
		cmd_out.data = rgba_s3;
		if (func_s3 == FUNC_WRITE) begin
			cmd_out.hit  = wr_in;
			cmd_out.addr = AW'(AW'(cy_s3) * AW'(SRC_W) + AW'(cx_s3));
		end else begin
			cmd_out.hit  = sx_in && sy_in;
			cmd_out.addr = AW'(AW'(sy_s3) * AW'(SRC_W) + AW'(sx_s3));
		end
	end

endmodule
`default_nettype wire

@@ sv/irn_cmd_queue.sv @@
`default_nettype none
module irn_cmd_queue import irn_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire cmd_t              din,
	input  wire logic              pop,
	output cmd_t                   dout,
	output logic [CMD_CW-1:0]      count
);

	cmd_t mem_q [CMD_DEPTH];
	logic [CMD_PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CMD_CW-1:0] count_q;

	assign dout  = mem_q[rd_ptr_q];
	assign count = count_q;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule
`default_nettype wire

@@ sv/irn_back.sv @@
`default_nettype none
module irn_back import irn_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [CMD_CW-1:0] cmd_count,
	input  wire cmd_t              cmd_in,
	output logic                   cmd_pop,
	output logic                   empty,
	input  wire logic              pop,
	output logic [RGBA_W-1:0]      rgba_out,
	output logic                   hit
);

	logic [RGBA_W:0] oq_q [OQ_DEPTH];
	logic [OQ_PW-1:0] oq_wr_q, oq_rd_q;
	logic [OQ_CW-1:0] oq_cnt_q;
	logic [OQ_CW:0] oq_occ;

	logic res_v_s1, hit_s1;
	logic [RGBA_W-1:0] rd_data;
	logic ram_we, ram_re, oq_push, oq_pop;
	logic [RGBA_W-1:0] res_data;

	// Issue a command only when the result queue has room for what is in flight.
	assign oq_occ  = (OQ_CW+1)'(oq_cnt_q) + (OQ_CW+1)'(res_v_s1);
	assign cmd_pop = (cmd_count != '0) && (oq_occ < (OQ_CW+1)'(OQ_DEPTH));
	assign ram_we  = cmd_pop && cmd_in.wr && cmd_in.hit;
	assign ram_re  = cmd_pop && !cmd_in.wr && cmd_in.hit;

	irn_ram #(
		.WIDTH(RGBA_W),
		.DEPTH(SRC_W * SRC_H)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cmd_in.addr),
		.wdata(cmd_in.data),
		.re   (ram_re),
		.raddr(cmd_in.addr),
		.rdata(rd_data)
	);

	// Read stage: one result per map command, lined up with the memory data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_s1 <= 1'b0;
		end else begin
			res_v_s1 <= cmd_pop && !cmd_in.wr;
		end
	end

	always_ff @(posedge clk) begin
		hit_s1 <= cmd_in.hit;
	end

	assign res_data = hit_s1 ? rd_data : '0;
	assign oq_push  = res_v_s1;
	assign oq_pop   = pop && !empty;

	// Result queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (oq_push) begin
				oq_wr_q <= oq_wr_q + 1'b1;
			end
			if (oq_pop) begin
				oq_rd_q <= oq_rd_q + 1'b1;
			end
			if (oq_push && !oq_pop) begin
				oq_cnt_q <= oq_cnt_q + 1'b1;
			end else if (oq_pop && !oq_push) begin
				oq_cnt_q <= oq_cnt_q - 1'b1;
			end
		end
	end

	// Result queue storage.
	always_ff @(posedge clk) begin
		if (oq_push) begin
			oq_q[oq_wr_q] <= {hit_s1, res_data};
		end
	end

	// The oldest result beat drives the outputs.
	assign empty    = (oq_cnt_q == '0);
	assign hit      = oq_q[oq_rd_q][RGBA_W];
	assign rgba_out = oq_q[oq_rd_q][RGBA_W-1:0];

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
module tb;
	import irn_pkg::*;

	localparam int HALF_PERIOD  = 1;
	localparam int RESET_CYCLES = 12;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 12;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 165;
	localparam int HOLD_AFTER   = 250;
	localparam int HOLD_CYCLES  = 120;

	// Register indexes that decode to nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

	typedef struct packed {
		logic [RGBA_W-1:0] rgba;
		logic              hit;
	} sample_t;

	// Mirror of the sampler: register copy, source pixels seen so far and the
	// samples still owed by the block.
	class rotate_scoreboard;
		logic signed [15:0] cos_reg;
		logic signed [15:0] sin_reg;
		logic [7:0]         center_x;
		logic [7:0]         center_y;
		logic signed [10:0] offset_x;
		logic signed [10:0] offset_y;
		logic [RGBA_W-1:0]  pixels [int];
		sample_t            owed [$];
		int                 errors;
		int                 checked;

		function new();
			cos_reg  = 16'sd16384;
			sin_reg  = 16'sd0;
			center_x = 8'd64;
			center_y = 8'd64;
			offset_x = 11'sd64;
			offset_y = 11'sd64;
			errors   = 0;
			checked  = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
			case (idx)
				CFG_COS:      cos_reg  = d;
				CFG_SIN:      sin_reg  = d;
				CFG_DST_CX:   center_x = d[7:0];
				CFG_DST_CY:   center_y = d[7:0];
				CFG_SRC_OFFX: offset_x = d[10:0];
				CFG_SRC_OFFY: offset_y = d[10:0];
				default: ;
			endcase
		endfunction

		// Q14 to integer, halves rounded away from zero.
		function int round_q14(int v);
			if (v >= 0) begin
				return (v + (1 << (FRAC_BITS - 1))) / (1 << FRAC_BITS);
			end
			return -((-v + (1 << (FRAC_BITS - 1))) / (1 << FRAC_BITS));
		endfunction

		// Inverse-map a destination pixel; returns 1 when it lands in the source.
		function bit locate(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
				output int sx, output int sy);
			int tx;
			int ty;
			tx = int'(x) - int'(center_x);
			ty = int'(y) - int'(center_y);
			sx = round_q14(tx * int'(cos_reg) + ty * int'(sin_reg)
				+ int'(offset_x) * (1 << FRAC_BITS));
			sy = round_q14(ty * int'(cos_reg) - tx * int'(sin_reg)
				+ int'(offset_y) * (1 << FRAC_BITS));
			return sx >= 0 && sx < SRC_W && sy >= 0 && sy < SRC_H;
		endfunction

		function bit has_pixel(int sx, int sy);
			return pixels.exists(sy * SRC_W + sx);
		endfunction

		function void note_input(logic f, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
				logic [RGBA_W-1:0] rgba);
			int sx;
			int sy;
			sample_t s;
			if (f == FUNC_WRITE) begin
				if (int'(x) < SRC_W && int'(y) < SRC_H) begin
					pixels[int'(y) * SRC_W + int'(x)] = rgba;
				end
			end else begin
				if (locate(x, y, sx, sy)) begin
					s.hit  = 1'b1;
					s.rgba = pixels[sy * SRC_W + sx];
				end else begin
					s.hit  = 1'b0;
					s.rgba = '0;
				end
				owed.push_back(s);
			end
		endfunction

		function void check_result(logic [RGBA_W-1:0] rgba, logic got_hit);
			sample_t want;
			if (owed.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat, expected none, actual rgba_out %h hit %b",
					$time, rgba, got_hit);
				return;
			end
			want = owed.pop_front();
			checked++;
			if (got_hit !== want.hit) begin
				errors++;
				$display("%0t: hit mismatch, expected %b actual %b", $time, want.hit, got_hit);
			end
			if (rgba !== want.rgba) begin
				errors++;
				$display("%0t: rgba_out mismatch, expected %h actual %h", $time, want.rgba, rgba);
			end
		endfunction

		function int outstanding();
			return owed.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  push;
	logic                  full;
	logic                  func;
	logic [COORD_W-1:0]    coord_x;
	logic [COORD_W-1:0]    coord_y;
	logic [RGBA_W-1:0]     rgba_in;
	logic                  empty;
	logic                  pop;
	logic [RGBA_W-1:0]     rgba_out;
	logic                  hit;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	rotate_scoreboard sb;
	int gap_odds;
	int stall_odds;
	int items_sent;
	int stall_left;
	bit held_off;
	int cycles;

	image_rotate_nearest_sampler u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.func     (func),
		.coord_x  (coord_x),
		.coord_y  (coord_y),
		.rgba_in  (rgba_in),
		.empty    (empty),
		.pop      (pop),
		.rgba_out (rgba_out),
		.hit      (hit),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// Run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Offer one item and hold it until the block takes the beat.
	task automatic send_item(input logic f, input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y, input logic [RGBA_W-1:0] rgba);
		if (gap_odds != 0 && $urandom_range(1, 100) <= gap_odds) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		push    <= 1'b1;
		func    <= f;
		coord_x <= x;
		coord_y <= y;
		rgba_in <= rgba;
		@(posedge clk);
		while (full) @(posedge clk);
		sb.note_input(f, x, y, rgba);
		items_sent++;
	endtask

	// Map a destination pixel; a source pixel it would read and not yet written is written first.
	task automatic map_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
		int sx;
		int sy;
		if (sb.locate(x, y, sx, sy) && !sb.has_pixel(sx, sy)) begin
			send_item(FUNC_WRITE, sx[COORD_W-1:0], sy[COORD_W-1:0], $urandom());
		end
		send_item(FUNC_MAP, x, y, $urandom());
	endtask

	// Wait for every owed sample, then for the tail of trailing writes.
	task automatic settle();
		push <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One register beat; valid stays high for the caller's next beat.
	task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, d);
	endtask

	// Write all registers; unused upper bits of narrow registers carry noise.
	task automatic program_regs(input int c, input int s, input int cx, input int cy,
			input int ox, input int oy);
		logic [15:0] junk;
		junk = 16'($urandom());
		cfg_beat(CFG_COS, c[15:0]);
		cfg_beat(CFG_SIN, s[15:0]);
		cfg_beat(CFG_DST_CX, {junk[7:0], cx[7:0]});
		cfg_beat(CFG_DST_CY, {junk[15:8], cy[7:0]});
		cfg_beat(CFG_SRC_OFFX, {junk[4:0], ox[10:0]});
		cfg_beat(CFG_SRC_OFFY, {junk[12:8], oy[10:0]});
		cfg_beat(CFG_SPARE_A, CFG_DATA_W'($urandom()));
		cfg_beat(CFG_SPARE_B, CFG_DATA_W'($urandom()));
		cfg_valid <= 1'b0;
	endtask

	function automatic int pick_odds();
		case ($urandom_range(0, 2))
			0:       return 0;
			1:       return 10;
			default: return 35;
		endcase
	endfunction

	// Result side: takes beats, stalls in bursts, and once holds off for a long stretch.
	initial begin
		pop        <= 1'b0;
		stall_left = 0;
		held_off   = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				sb.check_result(rgba_out, hit);
			end
			if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else if (!held_off && push && sb.checked >= HOLD_AFTER) begin
				held_off   = 1'b1;
				stall_left = HOLD_CYCLES - 1;
				pop <= 1'b0;
			end else if (stall_odds != 0 && $urandom_range(1, 100) <= stall_odds) begin
				stall_left = $urandom_range(1, 7) - 1;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Stimulus.
	initial begin
		int c;
		int s;
		int cx;
		int cy;
		int ox;
		int oy;
		int target;
		sb         = new();
		cycles     = 0;
		gap_odds   = 0;
		stall_odds = 0;
		items_sent = 0;
		arst_n    <= 1'b0;
		push      <= 1'b0;
		func      <= FUNC_WRITE;
		coord_x   <= '0;
		coord_y   <= '0;
		rgba_in   <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_COS;
		cfg_data  <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset registers map straight through: image corners, all-zero and all-one words.
		send_item(FUNC_WRITE, 8'd0, 8'd0, 32'h0000_0000);
		send_item(FUNC_WRITE, 8'd255, 8'd255, 32'hFFFF_FFFF);
		send_item(FUNC_WRITE, 8'd255, 8'd0, 32'hA5A5_A5A5);
		send_item(FUNC_WRITE, 8'd0, 8'd255, 32'h5A5A_5A5A);
		map_pixel(8'd0, 8'd0);
		map_pixel(8'd255, 8'd255);
		map_pixel(8'd255, 8'd0);
		map_pixel(8'd0, 8'd255);
		settle();

		// Quarter turn: one edge falls just outside the source.
		program_regs(0, 16384, 128, 128, 128, 128);
		map_pixel(8'd0, 8'd0);
		map_pixel(8'd255, 8'd0);
		map_pixel(8'd128, 8'd128);
		settle();

		// Half scale: exact halves round away from zero, negative half misses.
		program_regs(8192, 0, 1, 0, 0, 0);
		map_pixel(8'd0, 8'd0);
		map_pixel(8'd2, 8'd0);
		map_pixel(8'd4, 8'd3);
		map_pixel(8'd255, 8'd255);
		settle();

		// Extreme registers and offsets.
		program_regs(-16384, 16384, 255, 0, 1023, -1024);
		map_pixel(8'd0, 8'd0);
		map_pixel(8'd255, 8'd255);
		settle();
		program_regs(16384, -16384, 0, 255, -1024, 1023);
		map_pixel(8'd255, 8'd0);
		map_pixel(8'd0, 8'd255);
		settle();

		// Random phases, each under its own register setting; the last one runs flat out.
		for (int ph = 0; ph < PHASES; ph++) begin
			case ($urandom_range(0, 3))
				0: begin
					c  = $urandom_range(0, 1) ? 16384 : -16384;
					s  = $urandom_range(0, 1) ? 16384 : -16384;
					cx = $urandom_range(0, 1) * 255;
					cy = $urandom_range(0, 1) * 255;
					ox = $urandom_range(0, 1) * 255;
					oy = $urandom_range(0, 1) * 255;
				end
				1: begin
					c  = $urandom();
					s  = $urandom();
					cx = $urandom_range(0, 255);
					cy = $urandom_range(0, 255);
					ox = $urandom_range(0, 2047) - 1024;
					oy = $urandom_range(0, 255);
				end
				default: begin
					c  = int'($urandom_range(0, 32768)) - 16384;
					s  = int'($urandom_range(0, 32768)) - 16384;
					cx = $urandom_range(0, 255);
					cy = $urandom_range(0, 255);
					ox = $urandom_range(0, 255);
					oy = $urandom_range(0, 255);
				end
			endcase
			program_regs(c, s, cx, cy, ox, oy);
			if (ph == PHASES - 1) begin
				gap_odds   = 0;
				stall_odds = 0;
			end else begin
				gap_odds   = pick_odds();
				stall_odds = pick_odds();
			end
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) begin
				if ($urandom_range(0, 99) < 30) begin
					send_item(FUNC_WRITE, COORD_W'($urandom()), COORD_W'($urandom()),
						$urandom());
				end else begin
					map_pixel(COORD_W'($urandom()), COORD_W'($urandom()));
				end
			end
			settle();
		end

		if (sb.errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

@@ image_rotate_nearest_sampler.f @@
sv/irn_pkg.sv
sv/irn_ram.sv
sv/irn_front.sv
sv/irn_cmd_queue.sv
sv/irn_back.sv
sv/image_rotate_nearest_sampler.sv
tb/sv/tb.sv
